FILE: sv/slig_pkg.sv
// Shared types, constants and helpers of the sub-box linear index generator.
package slig_pkg;

  localparam int NUM_DIMS = 3;
  localparam int MAX_SIZE = 16;
  localparam int SIZE_W   = 5;
  localparam int CORNER_W = 4;
  localparam int IDX_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W   = $clog2(NUM_DIMS + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM2 = 2'd2;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;
  localparam logic MODE_CORNER_TO_END    = 1'b0;
  localparam logic MODE_ORIGIN_TO_CORNER = 1'b1;

  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [CORNER_W-1:0] digit_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef struct packed {
    logic  clear;
    logic  en;
    size_t mult;
    idx_t  addend;
  } mac_cmd_t;

  function automatic size_t eff_size(input size_t s);
    size_t r;
    r = s;
    if (s > size_t'(MAX_SIZE)) begin
      r = size_t'(MAX_SIZE);
    end
    return r;
  endfunction

endpackage

FILE: sv/slig_mac.sv
// Shared multiply-accumulate unit: acc <= acc * mult + addend, modulo the index width.
module slig_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  slig_pkg::mac_cmd_t cmd,
  output slig_pkg::idx_t    acc
);

  slig_pkg::idx_t acc_r;
  slig_pkg::idx_t acc_nxt;
  logic [slig_pkg::IDX_W+slig_pkg::SIZE_W-1:0] prod;

  always_comb begin
    prod    = acc_r * cmd.mult;
    acc_nxt = acc_r;
    if (cmd.clear) begin
      acc_nxt = '0;
    end else if (cmd.en) begin
      acc_nxt = prod[slig_pkg::IDX_W-1:0] + cmd.addend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

FILE: sv/subbox_linear_index_generator_top.sv
// Sub-box linear index generator: box state, step sequencer and output register.
// A start or next with a box loaded makes four passes through the shared
// multiply-accumulate unit (Horner order over the dims, then a pass adding the box base
// for a next), then loads the output register once it is free; an error result skips
// the passes. A new request is taken only after the output register has been loaded.
// Reset: synchronous active-low rst_n; sizes to 1, no box loaded, output empty.
module subbox_linear_index_generator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slig_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slig_pkg::SIZE_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic                              in_box_mode,
  input  logic [slig_pkg::CORNER_W-1:0]     in_corner_0,
  input  logic [slig_pkg::CORNER_W-1:0]     in_corner_1,
  input  logic [slig_pkg::CORNER_W-1:0]     in_corner_2,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [slig_pkg::IDX_W-1:0]        out_linear_index,
  output logic                              out_last_of_box,
  output logic                              out_error_flag
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [slig_pkg::STEP_W-1:0] step_r, step_nxt;

  slig_pkg::size_t  size_r [slig_pkg::NUM_DIMS];
  slig_pkg::size_t  ext_r  [slig_pkg::NUM_DIMS];
  slig_pkg::size_t  ext_nxt [slig_pkg::NUM_DIMS];
  slig_pkg::digit_t pos_r  [slig_pkg::NUM_DIMS];
  slig_pkg::digit_t pos_nxt [slig_pkg::NUM_DIMS];
  slig_pkg::digit_t dig_r  [slig_pkg::NUM_DIMS];
  slig_pkg::digit_t dig_nxt [slig_pkg::NUM_DIMS];
  slig_pkg::digit_t pos_adv [slig_pkg::NUM_DIMS];
  slig_pkg::digit_t corner [slig_pkg::NUM_DIMS];
  slig_pkg::idx_t   base_r, base_nxt;
  logic loaded_r, loaded_nxt;
  logic err_r, err_nxt;
  logic start_r, start_nxt;

  logic out_valid_r, out_valid_nxt;
  slig_pkg::idx_t out_idx_r;
  logic out_last_r, out_err_r;

  logic in_xfer, out_load, corner_bad, at_last;
  slig_pkg::mac_cmd_t cmd;
  slig_pkg::idx_t acc;

  slig_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .acc   (acc)
  );

  assign corner[0] = in_corner_0;
  assign corner[1] = in_corner_1;
  assign corner[2] = in_corner_2;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // corner range check and odometer advance
  always_comb begin
    logic carry;
    logic [slig_pkg::SIZE_W-1:0] inc;
    corner_bad = 1'b0;
    for (int k = 0; k < slig_pkg::NUM_DIMS; k++) begin
      if ({1'b0, corner[k]} >= slig_pkg::eff_size(size_r[k])) begin
        corner_bad = 1'b1;
      end
    end
    carry = 1'b1;
    for (int d = slig_pkg::NUM_DIMS - 1; d >= 0; d--) begin
      inc        = {1'b0, pos_r[d]} + 1'b1;
      pos_adv[d] = pos_r[d];
      if (carry) begin
        if (inc < ext_r[d]) begin
          pos_adv[d] = inc[slig_pkg::CORNER_W-1:0];
          carry      = 1'b0;
        end else begin
          pos_adv[d] = '0;
        end
      end
    end
  end

  always_comb begin
    at_last = 1'b1;
    for (int d = 0; d < slig_pkg::NUM_DIMS; d++) begin
      if (({1'b0, pos_r[d]} + 1'b1) != ext_r[d]) begin
        at_last = 1'b0;
      end
    end
  end

  // shared unit command
  always_comb begin
    cmd.clear  = in_xfer;
    cmd.en     = (state_r == ST_CALC);
    cmd.mult   = slig_pkg::size_t'(1);
    cmd.addend = start_r ? '0 : base_r;
    for (int d = 0; d < slig_pkg::NUM_DIMS; d++) begin
      if (step_r == slig_pkg::STEP_W'(d)) begin
        cmd.mult   = slig_pkg::eff_size(size_r[d]);
        cmd.addend = slig_pkg::idx_t'(dig_r[d]);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ext_nxt       = ext_r;
    pos_nxt       = pos_r;
    dig_nxt       = dig_r;
    base_nxt      = base_r;
    loaded_nxt    = loaded_r;
    err_nxt       = err_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          step_nxt  = '0;
          start_nxt = (in_req_type == slig_pkg::REQ_START);
          err_nxt   = 1'b0;
          state_nxt = ST_CALC;
          if (in_req_type == slig_pkg::REQ_START) begin
            if (corner_bad) begin
              err_nxt    = 1'b1;
              state_nxt  = ST_FIN;
              loaded_nxt = 1'b0;
              base_nxt   = '0;
              for (int k = 0; k < slig_pkg::NUM_DIMS; k++) begin
                ext_nxt[k] = '0;
                pos_nxt[k] = '0;
              end
            end else begin
              loaded_nxt = 1'b1;
              for (int k = 0; k < slig_pkg::NUM_DIMS; k++) begin
                pos_nxt[k] = '0;
                if (in_box_mode == slig_pkg::MODE_CORNER_TO_END) begin
                  ext_nxt[k] = slig_pkg::eff_size(size_r[k]) - {1'b0, corner[k]};
                  dig_nxt[k] = corner[k];
                end else begin
                  ext_nxt[k] = {1'b0, corner[k]} + 1'b1;
                  dig_nxt[k] = '0;
                end
              end
            end
          end else begin
            if (!loaded_r) begin
              err_nxt   = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              pos_nxt = pos_adv;
              dig_nxt = pos_adv;
            end
          end
        end
      end
      ST_CALC: begin
        if (step_r == slig_pkg::STEP_W'(slig_pkg::NUM_DIMS)) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (start_r && !err_r) begin
            base_nxt = acc;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      loaded_r    <= 1'b0;
      base_r      <= '0;
      err_r       <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < slig_pkg::NUM_DIMS; k++) begin
        size_r[k] <= slig_pkg::size_t'(1);
        ext_r[k]  <= '0;
        pos_r[k]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      loaded_r    <= loaded_nxt;
      base_r      <= base_nxt;
      err_r       <= err_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      ext_r       <= ext_nxt;
      pos_r       <= pos_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          slig_pkg::CFG_SIZE_DIM0: size_r[0] <= cfg_data;
          slig_pkg::CFG_SIZE_DIM1: size_r[1] <= cfg_data;
          slig_pkg::CFG_SIZE_DIM2: size_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    if (out_load) begin
      out_idx_r  <= err_r ? '0 : acc;
      out_last_r <= err_r ? 1'b0 : at_last;
      out_err_r  <= err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_linear_index = out_idx_r;
  assign out_last_of_box  = out_last_r;
  assign out_error_flag   = out_err_r;

endmodule
